@@ design/rect_pkg.sv @@
// ----------------------------------------------------------------------------
// rect_pkg
// Shared types, constants and round functions of the RECTANGLE-80 encryptor.
// ----------------------------------------------------------------------------
package rect_pkg;

    localparam int NUM_ROUNDS = 25;
    localparam int ROUND_W    = 5;
    localparam int BLOCK_W    = 64;
    localparam int KEY_W      = 80;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_WHITENING = 8'd3;

    localparam logic [ROUND_W-1:0] RC_MASK = 5'h1F;

    // block state and running key travel together down the cell row
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [BLOCK_W-1:0] state;
    } t_blk;

    function automatic logic [3:0] sbox(input logic [3:0] v);
        logic [3:0] s;
        case (v)
            4'h0: s = 4'h6;
            4'h1: s = 4'h5;
            4'h2: s = 4'hC;
            4'h3: s = 4'hA;
            4'h4: s = 4'h1;
            4'h5: s = 4'hE;
            4'h6: s = 4'h7;
            4'h7: s = 4'h9;
            4'h8: s = 4'hB;
            4'h9: s = 4'h0;
            4'hA: s = 4'h3;
            4'hB: s = 4'hD;
            4'hC: s = 4'h8;
            4'hD: s = 4'hF;
            4'hE: s = 4'h4;
            default: s = 4'h2;
        endcase
        return s;
    endfunction

    function automatic logic [ROUND_W-1:0] rcon(input logic [ROUND_W-1:0] rnd);
        logic [ROUND_W-1:0] c;
        case (rnd)
            5'd0:  c = 5'h01;
            5'd1:  c = 5'h02;
            5'd2:  c = 5'h04;
            5'd3:  c = 5'h09;
            5'd4:  c = 5'h12;
            5'd5:  c = 5'h05;
            5'd6:  c = 5'h0B;
            5'd7:  c = 5'h16;
            5'd8:  c = 5'h0C;
            5'd9:  c = 5'h19;
            5'd10: c = 5'h13;
            5'd11: c = 5'h07;
            5'd12: c = 5'h0F;
            5'd13: c = 5'h1F;
            5'd14: c = 5'h1E;
            5'd15: c = 5'h1C;
            5'd16: c = 5'h18;
            5'd17: c = 5'h11;
            5'd18: c = 5'h03;
            5'd19: c = 5'h06;
            5'd20: c = 5'h0D;
            5'd21: c = 5'h1B;
            5'd22: c = 5'h17;
            5'd23: c = 5'h0E;
            5'd24: c = 5'h1D;
            default: c = 5'h00;
        endcase
        return c & RC_MASK;
    endfunction

    // one full round on data and key, round index rnd
    function automatic t_blk rect_round(input t_blk b, input logic [ROUND_W-1:0] rnd);
        logic [ROW_W-1:0] s [4];
        logic [ROW_W-1:0] k [5];
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r3;
        logic [3:0]       col;
        logic [3:0]       sub;
        t_blk             res;
        for (int i = 0; i < 4; i++) begin
            s[i] = b.state[i*ROW_W +: ROW_W] ^ b.key[i*ROW_W +: ROW_W];
        end
        for (int i = 0; i < 5; i++) begin
            k[i] = b.key[i*ROW_W +: ROW_W];
        end
        // substitute all sixteen data columns
        for (int j = 0; j < ROW_W; j++) begin
            col = {s[3][j], s[2][j], s[1][j], s[0][j]};
            sub = sbox(col);
            for (int i = 0; i < 4; i++) begin
                s[i][j] = sub[i];
            end
        end
        // substitute the four low key columns
        for (int j = 0; j < 4; j++) begin
            col = {k[3][j], k[2][j], k[1][j], k[0][j]};
            sub = sbox(col);
            for (int i = 0; i < 4; i++) begin
                k[i][j] = sub[i];
            end
        end
        r0 = k[0];
        r1 = k[1];
        r3 = k[3];
        res.state = {{s[3][2:0], s[3][15:3]},
                     {s[2][3:0], s[2][15:4]},
                     {s[1][14:0], s[1][15]},
                     s[0]};
        res.key   = {r0,
                     {r3[3:0], r3[15:4]} ^ k[4],
                     r3,
                     k[2],
                     {r0[7:0], r0[15:8]} ^ r1 ^ {11'd0, rcon(rnd)}};
        return res;
    endfunction

endpackage

@@ design/rect_round_cell.sv @@
// ----------------------------------------------------------------------------
// rect_round_cell
// One round of the cell row: applies its round when enabled and registers
// the block and running key towards the next cell.
// ----------------------------------------------------------------------------
module rect_round_cell import rect_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_blk               i_blk,
    input  logic [ROUND_W-1:0] i_round,
    input  logic [ROUND_W-1:0] i_num_rounds,
    input  logic               i_ready,
    output logic               o_valid,
    output t_blk               o_blk,
    output logic               o_ready
);

    logic r_valid;
    t_blk r_blk;
    t_blk n_blk;

    // rounds beyond the programmed count pass the beat through unchanged
    assign n_blk   = (i_round < i_num_rounds) ? rect_round(i_blk, i_round) : i_blk;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_blk   = r_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blk <= n_blk;
        end
    end

endmodule

@@ design/rect_out_reg.sv @@
// ----------------------------------------------------------------------------
// rect_out_reg
// Output register: adds the final key when whitening is on and holds the
// ciphertext beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rect_out_reg import rect_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_blk               i_blk,
    input  logic               i_whiten,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output logic [BLOCK_W-1:0] o_ciphertext
);

    logic               r_valid;
    logic [BLOCK_W-1:0] r_ct;
    logic [BLOCK_W-1:0] n_ct;

    assign n_ct    = i_whiten ? (i_blk.state ^ i_blk.key[BLOCK_W-1:0]) : i_blk.state;
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_ciphertext = r_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ct <= n_ct;
        end
    end

endmodule

@@ design/rectangle80_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// rectangle80_block_encrypt
// RECTANGLE-80 block encryptor built as a row of 25 round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Program the key, round count and whitening through the configuration
//   channel (i_cfg_valid / o_cfg_ready, ready is always high) while the
//   block is idle. Plaintext beats enter on i_in_valid / o_in_stall and
//   ciphertext beats leave on o_out_valid / i_out_stall.
//   Every accepted beat passes 25 round cells, one round each, then the output
//   register, whatever the round count.
//   Rounds past the programmed count pass the beat through unchanged.
//   Throughput is one block per cycle while i_out_stall is low; each cell is
//   one round of the data path and key schedule.
//   While the receiver stalls, the output register holds its beat and the
//   cells behind it keep filling empty slots, so input is stalled only once
//   every cell holds a beat.
//   Reset clears all pipeline valids and sets the key to zero, the round
//   count to 25 and whitening on. Round counts above 25 act as 25.
// ----------------------------------------------------------------------------
module rectangle80_block_encrypt import rect_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BLOCK_W-1:0]    i_plaintext,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BLOCK_W-1:0]    o_ciphertext
);

    logic [ROW_W-1:0]   r_key_upper;
    logic [BLOCK_W-1:0] r_key_lower;
    logic [ROUND_W-1:0] r_round_count;
    logic               r_final_whitening;
    logic [ROUND_W-1:0] w_num_rounds;

    logic w_valid [NUM_ROUNDS+1];
    logic w_ready [NUM_ROUNDS+1];
    t_blk w_blk   [NUM_ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper       <= '0;
            r_key_lower       <= '0;
            r_round_count     <= ROUND_W'(NUM_ROUNDS);
            r_final_whitening <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_UPPER:       r_key_upper       <= i_cfg_data[ROW_W-1:0];
                CFG_KEY_LOWER:       r_key_lower       <= i_cfg_data;
                CFG_ROUND_COUNT:     r_round_count     <= i_cfg_data[ROUND_W-1:0];
                CFG_FINAL_WHITENING: r_final_whitening <= i_cfg_data[0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    assign w_num_rounds = (r_round_count > ROUND_W'(NUM_ROUNDS)) ?
                          ROUND_W'(NUM_ROUNDS) : r_round_count;

    // the key schedule restarts from the programmed key for every block
    assign w_valid[0]     = i_in_valid;
    assign w_blk[0].key   = {r_key_upper, r_key_lower};
    assign w_blk[0].state = i_plaintext;
    assign o_in_stall     = !w_ready[0];

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        rect_round_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_valid[g]),
            .i_blk        (w_blk[g]),
            .i_round      (ROUND_W'(g)),
            .i_num_rounds (w_num_rounds),
            .i_ready      (w_ready[g+1]),
            .o_valid      (w_valid[g+1]),
            .o_blk        (w_blk[g+1]),
            .o_ready      (w_ready[g])
        );
    end

    rect_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NUM_ROUNDS]),
        .i_blk        (w_blk[NUM_ROUNDS]),
        .i_whiten     (r_final_whitening),
        .i_stall      (i_out_stall),
        .o_ready      (w_ready[NUM_ROUNDS]),
        .o_valid      (o_out_valid),
        .o_ciphertext (o_ciphertext)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_valid[NUM_ROUNDS] && w_valid[1] && o_out_valid))
        else $error("input stalled with a free slot at the head or tail");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_last_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NUM_ROUNDS] && !w_ready[NUM_ROUNDS]) |=> w_valid[NUM_ROUNDS])
        else $error("last cell dropped a beat under stall");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_valid[NUM_ROUNDS]) |=> !o_out_valid)
        else $error("output beat repeated");

    a_round_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_num_rounds <= ROUND_W'(NUM_ROUNDS))
        else $error("effective round count out of range");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RECTANGLE-80 encryptor. Plaintext beats flow
// from a queue through a clocked driver; each accepted beat is encrypted by a
// behavioural copy of the cipher under the programmed key, round count and
// whitening, and the monitor compares the ciphertext beats in order. Both
// sides idle at random, the receiver twice holds off long enough to back the
// pipeline up, and the configuration is swept between drained phases.
// ----------------------------------------------------------------------------
module tb;
    import rect_pkg::*;

    localparam int WDOG_LIMIT  = 3000;
    localparam int GROUPS      = 9;
    localparam int GROUP_ITEMS = 72;

    localparam logic [3:0] SBOX_T [16] = '{
        4'h6, 4'h5, 4'hC, 4'hA, 4'h1, 4'hE, 4'h7, 4'h9,
        4'hB, 4'h0, 4'h3, 4'hD, 4'h8, 4'hF, 4'h4, 4'h2
    };
    localparam logic [4:0] RCON_T [25] = '{
        5'h01, 5'h02, 5'h04, 5'h09, 5'h12, 5'h05, 5'h0B, 5'h16, 5'h0C,
        5'h19, 5'h13, 5'h07, 5'h0F, 5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h11,
        5'h03, 5'h06, 5'h0D, 5'h1B, 5'h17, 5'h0E, 5'h1D
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [BLOCK_W-1:0]    i_plaintext = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BLOCK_W-1:0]    o_ciphertext;

    // copy of the programmed registers
    logic [15:0] key_hi     = '0;
    logic [63:0] key_lo     = '0;
    logic [4:0]  rounds_cfg = 5'd25;
    logic        whiten_cfg = 1'b1;

    logic [63:0] pending_pt  [$];
    logic [63:0] expected_ct [$];
    logic [63:0] ct_want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int err_cnt       = 0;
    int quiet_cycles  = 0;

    rectangle80_block_encrypt i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_plaintext  (i_plaintext),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ciphertext (o_ciphertext)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [15:0] rotl(input logic [15:0] w, input int n);
        return (w << n) | (w >> (16 - n));
    endfunction

    // substitute columns 0..ncols-1; row 0 is the column lsb
    function automatic logic [63:0] sbox_cols(input logic [63:0] w, input int ncols);
        logic [3:0] c;
        for (int j = 0; j < ncols; j++) begin
            c = SBOX_T[{w[48+j], w[32+j], w[16+j], w[j]}];
            w[j]    = c[0];
            w[16+j] = c[1];
            w[32+j] = c[2];
            w[48+j] = c[3];
        end
        return w;
    endfunction

    function automatic logic [63:0] encrypt_block(input logic [63:0] pt);
        logic [63:0] st;
        logic [63:0] kl;
        logic [15:0] kh;
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] k3;
        int          nr;
        nr = (rounds_cfg > 5'd25) ? 25 : int'(rounds_cfg);
        st = pt;
        kl = key_lo;
        kh = key_hi;
        for (int r = 0; r < nr; r++) begin
            st = sbox_cols(st ^ kl, 16);
            st = {rotl(st[63:48], 13), rotl(st[47:32], 12), rotl(st[31:16], 1), st[15:0]};
            kl = sbox_cols(kl, 4);
            r0 = kl[15:0];
            r1 = kl[31:16];
            k3 = kl[63:48];
            kl = {rotl(k3, 12) ^ kh, k3, kl[47:32], rotl(r0, 8) ^ r1 ^ {11'd0, RCON_T[r]}};
            kh = r0;
        end
        if (whiten_cfg)
            st = st ^ kl;
        return st;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic report_err(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("ERROR %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_ct.push_back(encrypt_block(i_plaintext));
            if (i_in_valid && o_in_stall) begin
                // hold the stalled beat
            end else if (pending_pt.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_plaintext <= pending_pt.pop_front();
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ct.size() == 0) begin
                report_err("unexpected ciphertext beat", o_ciphertext, 'x);
            end else begin
                ct_want = expected_ct.pop_front();
                if (o_ciphertext !== ct_want)
                    report_err("ciphertext", o_ciphertext, ct_want);
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_UPPER:       key_hi     = val[15:0];
            CFG_KEY_LOWER:       key_lo     = val;
            CFG_ROUND_COUNT:     rounds_cfg = val[4:0];
            CFG_FINAL_WHITENING: whiten_cfg = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // wait for the queue to empty and every beat to come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_pt.size() > 0 || i_in_valid || expected_ct.size() > 0);
    endtask

    task automatic set_cipher(input logic [63:0] khi, input logic [63:0] klo,
                              input logic [63:0] nr, input logic [63:0] wh);
        cfg_write(CFG_KEY_UPPER, khi);
        cfg_write(CFG_KEY_LOWER, klo);
        cfg_write(CFG_ROUND_COUNT, nr);
        cfg_write(CFG_FINAL_WHITENING, wh);
    endtask

    // ------------------------------------------------------------- stimulus
    initial begin
        int sel;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero key, full rounds, whitening on
        pending_pt.push_back('0);
        pending_pt.push_back('1);
        pending_pt.push_back(64'h0123_4567_89AB_CDEF);
        pending_pt.push_back(64'h8000_0000_0000_0001);
        drain();

        // all-ones key, single round, no whitening; upper data bits must drop
        set_cipher('1, '1, 64'hFFFF_FFFF_FFFF_FFE1, 64'hFFFF_FFFF_FFFF_FFFE);
        pending_pt.push_back('0);
        pending_pt.push_back('1);
        pending_pt.push_back(64'h5555_AAAA_5555_AAAA);
        drain();

        // no rounds: whitening with the raw key only
        set_cipher(rand64(), rand64(), 64'd0, 64'd3);
        pending_pt.push_back('0);
        pending_pt.push_back('1);
        pending_pt.push_back(rand64());
        drain();

        // no rounds, no whitening: straight through
        cfg_write(CFG_FINAL_WHITENING, 64'd0);
        pending_pt.push_back(rand64());
        pending_pt.push_back(rand64());
        drain();

        // round counts past the last constant clamp to the full cipher
        set_cipher(rand64(), rand64(), 64'd31, 64'd1);
        pending_pt.push_back('0);
        pending_pt.push_back(rand64());
        drain();
        cfg_write(CFG_ROUND_COUNT, 64'd26);
        pending_pt.push_back(rand64());
        drain();
        cfg_write(CFG_ROUND_COUNT, 64'd25);
        cfg_write(CFG_FINAL_WHITENING, 64'd0);
        pending_pt.push_back(rand64());
        drain();

        // writes to unknown registers leave the settings alone
        cfg_write(8'd4, '1);
        cfg_write(8'h80, '1);
        cfg_write(8'hFF, '0);
        pending_pt.push_back(rand64());
        pending_pt.push_back('1);
        drain();

        for (int g = 0; g < GROUPS; g++) begin
            case (g / 3)
                0:       begin send_idle_pct = 20; recv_idle_pct = 65; end
                1:       begin send_idle_pct = 65; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            set_cipher((g == 1) ? '1 : (g == 0) ? '0 : rand64(),
                       (g == 1) ? '1 : (g == 0) ? '0 : rand64(),
                       (g % 3 == 0) ? 64'd25 : 64'($urandom_range(31)),
                       64'($urandom_range(1)));
            if (g == 5)
                cfg_write(8'($urandom_range(255, 4)), rand64());
            @(negedge i_clk);
            // back the pipeline up until the input stalls
            if (g == 2 || g == 6)
                hold_left = 120;
            for (int n = 0; n < GROUP_ITEMS; n++) begin
                sel = $urandom_range(15);
                case (sel)
                    0:       pending_pt.push_back('0);
                    1:       pending_pt.push_back('1);
                    default: pending_pt.push_back(rand64());
                endcase
                // pause the sender until everything is back, then carry on
                if (g == 4 && n == GROUP_ITEMS / 2)
                    drain();
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
